>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the queue block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fqsu_pkg.sv
// Package with sizes, codes and types of the ring-buffer queue.
package fqsu_pkg;

    // Queue depth and derived widths
    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OP_W = 3;
    localparam int POS_W = 4;
    localparam int ST_W = 3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [OP_W-1:0] t_op;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [ST_W-1:0] t_status;

    // Operation codes
    localparam t_op OP_INSERT = 3'd0;
    localparam t_op OP_DELETE = 3'd1;
    localparam t_op OP_SEARCH = 3'd2;
    localparam t_op OP_CHANGE = 3'd3;
    localparam t_op OP_DISPLAY = 3'd4;

    // Result status codes
    localparam t_status ST_OK = 3'd0;
    localparam t_status ST_OVERFLOW = 3'd1;
    localparam t_status ST_EMPTY = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_BADPOS = 3'd4;

endpackage

>>> hdl/fifo_queue_with_search_and_update_core.sv
// Top level of the ring-buffer queue with search, change and display.
//
// A transaction is accepted when start is high and busy is low; busy then stays high
// until the last result of that transaction has been put on the result ports. Each
// result is shown for exactly one cycle with o_valid high and cannot be held off.
// Insert, change and ignored opcodes go from the execute state straight back to idle,
// as do delete, search and display on an empty queue. On a non-empty queue these go
// on to the walk state: delete takes the head entry, search stops at the first match
// or at the tail, and display puts out one result per cycle up to the tail. The
// entries sit in a RAM with one read port and registered read data, walked one entry
// per cycle by a single offset counter and a single 32-bit comparator. Entries need no
// clearing after reset: read data is used only from occupied slots.
`include "assert_macros.svh"

module fifo_queue_with_search_and_update_core
    import fqsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_op     i_opcode,
    input  t_word   i_value,
    input  t_pos    i_position,
    output logic    o_valid,
    output t_status o_status,
    output t_word   o_data,
    output t_pos    o_found_position,
    output logic    o_last
);

    localparam int SUM_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0] r_state, n_state;
    t_idx       r_head, n_head;
    t_cnt       r_occ, n_occ;
    t_idx       r_off, n_off;
    t_op        r_op;
    t_word      r_value;
    t_pos       r_pos;

    logic       r_valid, n_valid;
    t_status    r_status, n_status;
    t_word      r_data, n_data;
    t_pos       r_fpos, n_fpos;
    logic       r_last, n_last;

    logic       ram_we;
    t_idx       ram_waddr;
    t_idx       ram_raddr;
    t_idx       rd_off;
    t_word      ram_rdata;
    logic       match;
    logic       at_tail;
    t_cnt       off_cnt_next;

    // Ring slot of an offset from the head
    function automatic t_idx f_slot(input t_idx head, input t_idx off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    fqsu_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_value),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign busy = (r_state != S_IDLE);

    // Shared compare unit and walk bookkeeping
    assign match = (ram_rdata == r_value);
    assign off_cnt_next = CNT_W'(r_off) + CNT_W'(1);
    assign at_tail = (off_cnt_next == r_occ);

    // Issue the read one offset ahead of the data being examined
    assign rd_off = (r_state == S_WALK) ? (r_off + IDX_W'(1)) : '0;
    assign ram_raddr = f_slot(r_head, rd_off);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_head = r_head;
        n_occ = r_occ;
        n_off = r_off;
        n_valid = 1'b0;
        n_status = ST_OK;
        n_data = '0;
        n_fpos = '0;
        n_last = 1'b1;
        ram_we = 1'b0;
        ram_waddr = f_slot(r_head, r_occ[IDX_W-1:0]);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_IDLE;
                n_off = '0;
                unique case (r_op) inside
                    OP_INSERT: begin
                        n_valid = 1'b1;
                        if (r_occ >= CNT_W'(DEPTH)) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            ram_we = 1'b1;
                            n_occ = r_occ + CNT_W'(1);
                        end
                    end
                    OP_CHANGE: begin
                        n_valid = 1'b1;
                        ram_waddr = f_slot(r_head, IDX_W'(r_pos - POS_W'(1)));
                        if (r_pos == '0 || CMP_W'(r_pos) > CMP_W'(r_occ)) begin
                            n_status = ST_BADPOS;
                        end else begin
                            ram_we = 1'b1;
                        end
                    end
                    OP_DELETE, OP_SEARCH, OP_DISPLAY: begin
                        if (r_occ == '0) begin
                            n_valid = 1'b1;
                            n_status = (r_op == OP_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_WALK: begin
                unique case (r_op) inside
                    OP_DELETE: begin
                        n_valid = 1'b1;
                        n_data = ram_rdata;
                        n_head = f_slot(r_head, IDX_W'(1));
                        n_occ = r_occ - CNT_W'(1);
                        n_state = S_IDLE;
                    end
                    OP_SEARCH: begin
                        if (match) begin
                            n_valid = 1'b1;
                            n_fpos = POS_W'(r_off) + POS_W'(1);
                            n_state = S_IDLE;
                        end else if (at_tail) begin
                            n_valid = 1'b1;
                            n_status = ST_NOTFOUND;
                            n_state = S_IDLE;
                        end else begin
                            n_off = r_off + IDX_W'(1);
                        end
                    end
                    OP_DISPLAY: begin
                        n_valid = 1'b1;
                        n_data = ram_rdata;
                        n_last = at_tail;
                        if (at_tail) begin
                            n_state = S_IDLE;
                        end else begin
                            n_off = r_off + IDX_W'(1);
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_occ <= '0;
            r_off <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_occ <= n_occ;
            r_off <= n_off;
            r_valid <= n_valid;
        end
    end

    // Capture the transaction and hold the result payload
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op <= i_opcode;
            r_value <= i_value;
            r_pos <= i_position;
        end
        r_status <= n_status;
        r_data <= n_data;
        r_fpos <= n_fpos;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_data = r_data;
    assign o_found_position = r_fpos;
    assign o_last = r_last;

    // Checks
    `CHK_IMPLY(a_occ_range, i_clk, i_rst_n, 1'b1, r_occ <= CNT_W'(DEPTH),
               "occupancy beyond depth")
    `CHK_NEXT(a_accept_exec, i_clk, i_rst_n, start && !busy, r_state == S_EXEC,
              "accepted transaction did not start")
    `CHK_IMPLY(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(r_state) != S_IDLE,
               "result without a transaction in flight")
    `CHK_IMPLY(a_more_only_display, i_clk, i_rst_n, o_valid && !o_last,
               r_op == OP_DISPLAY && busy, "non-final result outside display")

endmodule

>>> hdl/fqsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> test/queue_result_checker.sv
`timescale 1ns / 1ps
// Checker for the queue block: predicts every command and compares each result strobe.
module queue_result_checker
    import fqsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    busy,
    input  t_op     i_opcode,
    input  t_word   i_value,
    input  t_pos    i_position,
    input  logic    o_valid,
    input  t_status o_status,
    input  t_word   o_data,
    input  t_pos    o_found_position,
    input  logic    o_last,
    output int      fail_count,
    output int      pending_count
);

    typedef struct {
        t_status status;
        t_word   data;
        t_pos    found_position;
        logic    last;
    } t_queue_result;

    // Results still owed by the block, oldest first
    t_queue_result expected_results[$];

    // Shadow copy of the ring buffer
    t_word ring_words[DEPTH];
    t_idx  ring_head;
    t_cnt  ring_count;

    function automatic t_idx ring_slot(input int offset);
        return t_idx'((int'(ring_head) + offset) % DEPTH);
    endfunction

    task automatic owe_result(input t_status st, input t_word word, input t_pos pos,
                              input logic fin);
        t_queue_result res;
        res.status = st;
        res.data = word;
        res.found_position = pos;
        res.last = fin;
        expected_results.push_back(res);
    endtask

    // Apply one command to the shadow queue and queue up what it must produce
    task automatic predict_queue_op(input t_op op, input t_word val, input t_pos pos);
        bit hit;
        hit = 1'b0;
        case (op)
            OP_INSERT: begin
                if (int'(ring_count) >= DEPTH) begin
                    owe_result(ST_OVERFLOW, '0, '0, 1'b1);
                end else begin
                    ring_words[ring_slot(int'(ring_count))] = val;
                    ring_count = ring_count + 1'b1;
                    owe_result(ST_OK, '0, '0, 1'b1);
                end
            end
            OP_DELETE: begin
                if (ring_count == 0) begin
                    owe_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    owe_result(ST_OK, ring_words[ring_head], '0, 1'b1);
                    ring_head = ring_slot(1);
                    ring_count = ring_count - 1'b1;
                end
            end
            OP_SEARCH: begin
                // First match from the head wins; an empty queue reads nothing
                for (int k = 0; k < int'(ring_count); k++) begin
                    if (!hit && ring_words[ring_slot(k)] == val) begin
                        owe_result(ST_OK, '0, t_pos'(k + 1), 1'b1);
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    owe_result(ST_NOTFOUND, '0, '0, 1'b1);
                end
            end
            OP_CHANGE: begin
                if (pos == 0 || int'(pos) > int'(ring_count)) begin
                    owe_result(ST_BADPOS, '0, '0, 1'b1);
                end else begin
                    ring_words[ring_slot(int'(pos) - 1)] = val;
                    owe_result(ST_OK, '0, '0, 1'b1);
                end
            end
            OP_DISPLAY: begin
                if (ring_count == 0) begin
                    owe_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int k = 0; k < int'(ring_count); k++) begin
                        owe_result(ST_OK, ring_words[ring_slot(k)], '0,
                                   (k + 1 == int'(ring_count)));
                    end
                end
            end
            default: begin
                // Unused opcodes: no result, no state change
            end
        endcase
    endtask

    // Match one result strobe against the oldest owed result
    task automatic check_result();
        t_queue_result want;
        if (expected_results.size() == 0) begin
            $error("result with none expected: status %0d data %0d pos %0d last %0b",
                   o_status, o_data, o_found_position, o_last);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (o_status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                fail_count++;
            end
            if (o_data !== want.data) begin
                $error("data mismatch: expected %0d, actual %0d", want.data, o_data);
                fail_count++;
            end
            if (o_found_position !== want.found_position) begin
                $error("found_position mismatch: expected %0d, actual %0d",
                       want.found_position, o_found_position);
                fail_count++;
            end
            if (o_last !== want.last) begin
                $error("last mismatch: expected %0b, actual %0b", want.last, o_last);
                fail_count++;
            end
        end
    endtask

    // Check results before predicting, since a strobe never belongs to a fresh command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_head = '0;
            ring_count = '0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (o_valid) begin
                check_result();
            end
            if (start && !busy) begin
                predict_queue_op(i_opcode, i_value, i_position);
            end
        end
        pending_count = expected_results.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the queue block: clock, reset, command stimulus, watchdog and verdict.
module testbench;
    import fqsu_pkg::*;

    localparam t_op OP_UNUSED_FIRST = 3'd5;
    localparam t_op OP_UNUSED_LAST = 3'd7;
    localparam int  RANDOM_COMMANDS = 410;
    localparam int  PHASE_COUNT = 5;
    localparam int  STALL_LIMIT = 2000;
    localparam int  SETTLE_CYCLES = DEPTH + 12;
    localparam int  POOL_SIZE = 8;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_op     i_opcode;
    t_word   i_value;
    t_pos    i_position;
    logic    o_valid;
    t_status o_status;
    t_word   o_data;
    t_pos    o_found_position;
    logic    o_last;

    int    fail_count;
    int    pending_count;
    int    quiet_cycles = 0;
    t_word recent_words[POOL_SIZE];

    fifo_queue_with_search_and_update_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_data          (o_data),
        .o_found_position(o_found_position),
        .o_last          (o_last)
    );

    queue_result_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_data          (o_data),
        .o_found_position(o_found_position),
        .o_last          (o_last),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort when neither a transaction nor a result moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** fifo_queue_with_search_and_update_core: FAILED **");
                $finish;
            end
        end
    end

    // Present one command and hold it until the block takes it
    task automatic issue_command(input t_op op, input t_word val, input t_pos pos);
        logic was_busy;
        @(negedge i_clk);
        start = 1'b1;
        i_opcode = op;
        i_value = val;
        i_position = pos;
        was_busy = busy;
        @(posedge i_clk);
        while (was_busy) begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end
    endtask

    // Drop start for the requested number of cycles with noise on the payload
    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
            i_opcode = t_op'($urandom);
            i_value = t_word'($urandom);
            i_position = t_pos'($urandom);
        end
    endtask

    // Hold the sender until every owed result has arrived
    task automatic wait_for_drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic t_word pick_word(input int pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < pool_pct) begin
            return recent_words[$urandom_range(0, POOL_SIZE - 1)];
        end else if (r < pool_pct + 4) begin
            return ($urandom_range(0, 1) != 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return t_word'($urandom);
    endfunction

    // Issue one random command; report whether it is one the block acts on
    task automatic random_command(input bit filling, output bit acted);
        int    r;
        t_op   op;
        t_word val;
        t_pos  pos;
        r = $urandom_range(0, 99);
        pos = ($urandom_range(0, 99) < 80) ? t_pos'($urandom_range(1, DEPTH))
                                           : t_pos'($urandom_range(0, 15));
        val = pick_word(35);
        if (r < 4) begin
            op = t_op'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end else if (r < (filling ? 50 : 22)) begin
            op = OP_INSERT;
        end else if (r < (filling ? 62 : 52)) begin
            op = OP_DELETE;
        end else if (r < 70) begin
            op = OP_SEARCH;
            val = pick_word(70);
        end else if (r < 82) begin
            op = OP_CHANGE;
        end else begin
            op = OP_DISPLAY;
        end
        // Remember written words so later searches can hit them
        if (op == OP_INSERT || op == OP_CHANGE) begin
            recent_words[$urandom_range(0, POOL_SIZE - 1)] = val;
        end
        issue_command(op, val, pos);
        acted = (op <= OP_DISPLAY);
    endtask

    initial begin
        int  phase_idle_pct[PHASE_COUNT];
        int  issued;
        int  per_phase;
        bit  filling;
        bit  no_gaps;
        bit  acted;

        phase_idle_pct = '{0, 62, 19, 0, 62};
        start = 1'b0;
        i_opcode = OP_INSERT;
        i_value = '0;
        i_position = '0;
        i_rst_n = 1'b0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            recent_words[k] = t_word'($urandom);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty queue corners
        issue_command(OP_DELETE, '0, '0);
        issue_command(OP_SEARCH, '0, '0);
        issue_command(OP_DISPLAY, '0, '0);
        issue_command(OP_CHANGE, 32'sd3, 4'd1);
        // Fill to the brim with extreme and duplicate words, then overflow
        issue_command(OP_INSERT, 32'sh80000000, '0);
        issue_command(OP_INSERT, 32'sh7FFFFFFF, '0);
        issue_command(OP_INSERT, 32'sd0, '0);
        issue_command(OP_INSERT, -32'sd1, '0);
        issue_command(OP_INSERT, 32'sd5, '0);
        issue_command(OP_INSERT, 32'sd5, '0);
        issue_command(OP_INSERT, 32'sh55555555, '0);
        issue_command(OP_INSERT, 32'shAAAAAAAA, '0);
        issue_command(OP_INSERT, 32'sd1, '0);
        issue_command(OP_DISPLAY, '0, '0);
        // Search: head match, duplicate match, miss
        issue_command(OP_SEARCH, 32'sh80000000, '0);
        issue_command(OP_SEARCH, 32'sd5, '0);
        issue_command(OP_SEARCH, 32'sd123, '0);
        // Change: zero, tail, past the end, top of the field, head
        issue_command(OP_CHANGE, 32'sd9, 4'd0);
        issue_command(OP_CHANGE, 32'sh12345678, 4'd8);
        issue_command(OP_CHANGE, 32'sd9, 4'd9);
        issue_command(OP_CHANGE, 32'sd9, 4'd15);
        issue_command(OP_CHANGE, 32'sd77, 4'd1);
        // Free the head and wrap the tail round the ring
        issue_command(OP_DELETE, '0, '0);
        issue_command(OP_INSERT, 32'sd7, '0);
        issue_command(OP_DISPLAY, '0, '0);
        for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) begin
            issue_command(t_op'(k), t_word'($urandom), t_pos'($urandom));
        end
        wait_for_drain();

        // Random phases, each with a sender idle rate taken from a per-phase table
        per_phase = RANDOM_COMMANDS / PHASE_COUNT;
        filling = 1'b1;
        no_gaps = 1'b0;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            issued = 0;
            while (issued < per_phase) begin
                if (issued % 16 == 0) begin
                    filling = $urandom_range(0, 1);
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                random_command(filling, acted);
                if (acted) begin
                    issued++;
                end
                if (!no_gaps && $urandom_range(0, 99) < phase_idle_pct[phase]) begin
                    hold_off($urandom_range(1, 6));
                end
            end
            wait_for_drain();
        end

        // Let any trailing strobes show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** fifo_queue_with_search_and_update_core: PASSED **");
        end else begin
            $display("** fifo_queue_with_search_and_update_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> fifo_queue_with_search_and_update_core.f
+incdir+hdl
hdl/fqsu_pkg.sv
hdl/fqsu_ram.sv
hdl/fifo_queue_with_search_and_update_core.sv
test/queue_result_checker.sv
test/testbench.sv
